// ----- rtl/longest_common_subsequence_core_macros.svh -----
// Assertion macros used by the port checker.
`ifndef LONGEST_COMMON_SUBSEQUENCE_CORE_MACROS_SVH
`define LONGEST_COMMON_SUBSEQUENCE_CORE_MACROS_SVH
`define LCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/lcs_pkg.sv -----
// Package with types and constants of the LCS core.
package lcs_pkg;
    localparam int unsigned LcsMaxLen = 64;

    localparam logic OpFirst  = 1'b0;
    localparam logic OpSecond = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] symbol;
        logic       has_symbol;
        logic       last;
    } t_lcs_in;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       last_res;
        logic       empty_res;
        logic       truncated;
    } t_lcs_out;

    typedef enum logic [3:0] {
        ST_LOAD1,
        ST_LOAD2,
        ST_FROW,
        ST_FRD,
        ST_FWAIT,
        ST_FWR,
        ST_TOT,
        ST_TRD,
        ST_TWAIT,
        ST_TDEC,
        ST_ORD,
        ST_OWAIT,
        ST_OUT
    } t_lcs_state;
endpackage

// ----- rtl/longest_common_subsequence_core.sv -----
// LCS core: loads two byte sequences, then emits their longest common
// subsequence in forward order. An item for the wrong sequence is dropped
// without a result. After the second sequence ends, the block fills the
// score table cell by cell (read up, read diagonal, write through one score
// memory port), then traces back through the table (at most m+n steps for
// lengths m and n) and sends the results, which wait while the receiver
// stalls. No item is taken during that time. The score table has
// (MaxLen+1)*(MaxLen+1) entries of $clog2(MaxLen+1) bits.
module longest_common_subsequence_core
    import lcs_pkg::*;
#(
    parameter int unsigned MaxLen = LcsMaxLen
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_lcs_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_lcs_out o_data
);
    localparam int unsigned Aw = $clog2(MaxLen);
    localparam int unsigned Lw = $clog2(MaxLen + 1);
    localparam int unsigned Dim = MaxLen + 1;
    localparam int unsigned TDepth = Dim * Dim;
    localparam int unsigned Tw = $clog2(TDepth);
    localparam int unsigned SeqAw = (Aw > 0) ? Aw : 1;
    localparam int unsigned SeqDepth = (MaxLen > 1) ? MaxLen : 2;

    t_lcs_state r_state, n_state;
    logic [Lw-1:0] r_len1, n_len1, r_len2, n_len2;
    logic [Lw-1:0] r_i, n_i, r_j, n_j;
    logic [Lw-1:0] r_pos, n_pos, r_tot, n_tot;
    logic [Lw-1:0] r_up, n_up;
    logic [Lw-1:0] r_diag, n_diag;
    logic          r_ovf, n_ovf;
    logic          r_ov, n_ov;
    t_lcs_out      r_out, n_out;

    logic acc_in;
    logic acc_out;
    assign acc_in = i_valid && !o_stall;
    assign acc_out = r_ov && !i_stall;

    // sequence and traceback memories
    logic            s1_we, s2_we, tb_we;
    logic [SeqAw-1:0] s1_wa, s2_wa, s1_ra, s2_ra, tb_wa, tb_ra;
    logic [7:0]      s1_rd, s2_rd, tb_rd, tb_wd;

    // score memory
    logic          sc_we;
    logic [Tw-1:0] sc_wa, sc_ra;
    logic [Lw-1:0] sc_wd, sc_rd;

    lcs_ram #(.Width(8), .Depth(SeqDepth)) u_seq1 (
        .i_clk(i_clk), .i_we(s1_we), .i_waddr(s1_wa), .i_wdata(i_data.symbol),
        .i_raddr(s1_ra), .o_rdata(s1_rd));
    lcs_ram #(.Width(8), .Depth(SeqDepth)) u_seq2 (
        .i_clk(i_clk), .i_we(s2_we), .i_waddr(s2_wa), .i_wdata(i_data.symbol),
        .i_raddr(s2_ra), .o_rdata(s2_rd));
    lcs_ram #(.Width(8), .Depth(SeqDepth)) u_trace (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_wa), .i_wdata(tb_wd),
        .i_raddr(tb_ra), .o_rdata(tb_rd));
    lcs_ram #(.Width(Lw), .Depth(TDepth)) u_score (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_wa), .i_wdata(sc_wd),
        .i_raddr(sc_ra), .o_rdata(sc_rd));

    function automatic logic [Tw-1:0] taddr(input logic [Lw-1:0] a, input logic [Lw-1:0] b);
        logic [2*Tw-1:0] p;
        p = (2*Tw)'(a) * (2*Tw)'(Dim) + (2*Tw)'(b);
        return p[Tw-1:0];
    endfunction

    logic [Lw-1:0] im1, jm1;
    assign im1 = r_i - Lw'(1);
    assign jm1 = r_j - Lw'(1);

    // sequence read addresses follow the current cell
    assign s1_ra = SeqAw'(im1);
    assign s2_ra = SeqAw'(jm1);
    assign s1_wa = SeqAw'(r_len1);
    assign s2_wa = SeqAw'(r_len2);
    assign tb_wa = SeqAw'(r_pos - Lw'(1));
    assign tb_wd = s1_rd;
    assign tb_ra = SeqAw'(r_pos);

    logic match;
    assign match = (s1_rd == s2_rd);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD1: begin
                if (acc_in && i_data.op == OpFirst && i_data.last) begin
                    n_state = ST_LOAD2;
                end
            end
            ST_LOAD2: begin
                if (acc_in && i_data.op == OpSecond && i_data.last) begin
                    n_state = ST_FROW;
                end
            end
            ST_FROW: begin
                if (r_j == r_len2) begin
                    n_state = (r_len1 == '0) ? ST_TOT : ST_FRD;
                end
            end
            ST_FRD: begin
                if (r_j != '0) begin
                    n_state = ST_FWAIT;
                end else if (r_len2 == '0 && r_i == r_len1) begin
                    n_state = ST_TOT;
                end
            end
            ST_FWAIT: n_state = ST_FWR;
            ST_FWR: begin
                if (r_j == r_len2 && r_i == r_len1) begin
                    n_state = ST_TOT;
                end else begin
                    n_state = ST_FRD;
                end
            end
            ST_TOT:   n_state = ST_TRD;
            ST_TRD: begin
                if (r_i == '0 || r_j == '0) begin
                    n_state = ST_ORD;
                end else begin
                    n_state = ST_TWAIT;
                end
            end
            ST_TWAIT: n_state = ST_TDEC;
            ST_TDEC:  n_state = ST_TRD;
            ST_ORD: begin
                if (!r_ov || acc_out) begin
                    n_state = (r_tot == '0) ? ST_LOAD1 : ST_OWAIT;
                end
            end
            ST_OWAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_ov || acc_out) begin
                    n_state = (r_pos == r_tot - Lw'(1)) ? ST_LOAD1 : ST_OWAIT;
                end
            end
            default:  n_state = ST_LOAD1;
        endcase
    end

    always_comb begin
        n_len1 = r_len1;
        n_len2 = r_len2;
        n_i    = r_i;
        n_j    = r_j;
        n_pos  = r_pos;
        n_tot  = r_tot;
        n_up   = r_up;
        n_diag = r_diag;
        n_ovf  = r_ovf;
        n_ov   = r_ov && !acc_out;
        n_out  = r_out;
        o_stall = 1'b1;
        s1_we  = 1'b0;
        s2_we  = 1'b0;
        tb_we  = 1'b0;
        sc_we  = 1'b0;
        sc_wa  = taddr(r_i, r_j);
        sc_wd  = '0;
        sc_ra  = taddr(r_i, r_j);
        case (r_state)
            ST_LOAD1, ST_LOAD2: begin
                o_stall = 1'b0;
                if (acc_in && i_data.op == ((r_state == ST_LOAD1) ? OpFirst : OpSecond)) begin
                    if (i_data.has_symbol) begin
                        if (r_state == ST_LOAD1) begin
                            if (r_len1 < Lw'(MaxLen)) begin
                                s1_we = 1'b1;
                                n_len1 = r_len1 + Lw'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            if (r_len2 < Lw'(MaxLen)) begin
                                s2_we = 1'b1;
                                n_len2 = r_len2 + Lw'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    if (i_data.last && r_state == ST_LOAD2) begin
                        n_i = '0;
                        n_j = '0;
                    end
                end
            end
            ST_FROW: begin
                // clear row zero, then step to first cell
                sc_we = 1'b1;
                sc_wa = taddr('0, r_j);
                if (r_j == r_len2) begin
                    n_i = Lw'(1);
                    n_j = '0;
                    n_diag = '0;
                end else begin
                    n_j = r_j + Lw'(1);
                end
            end
            ST_FRD: begin
                if (r_j == '0) begin
                    // clear column zero of this row
                    sc_we = 1'b1;
                    sc_wa = taddr(r_i, '0);
                    if (r_len2 == '0) begin
                        n_i = r_i + Lw'(1);
                    end else begin
                        n_j = Lw'(1);
                    end
                end else begin
                    sc_ra = taddr(im1, r_j);
                end
            end
            ST_FWAIT: begin
                sc_ra = taddr(im1, jm1);
                n_up = sc_rd;
            end
            ST_FWR: begin
                // left cell was written in the previous step and is in r_diag
                sc_we = 1'b1;
                if (match) begin
                    sc_wd = sc_rd + Lw'(1);
                end else begin
                    sc_wd = (r_up > r_diag) ? r_up : r_diag;
                end
                n_diag = sc_wd;
                if (r_j == r_len2) begin
                    n_i = r_i + Lw'(1);
                    n_j = '0;
                    n_diag = '0;
                end else begin
                    n_j = r_j + Lw'(1);
                end
            end
            ST_TOT: begin
                n_i = r_len1;
                n_j = r_len2;
                sc_ra = taddr(r_len1, r_len2);
            end
            ST_TRD: begin
                if (r_tot == '0 && r_i == r_len1 && r_j == r_len2) begin
                    n_tot = sc_rd;
                    n_pos = sc_rd;
                end
                sc_ra = taddr(im1, r_j);
            end
            ST_TWAIT: begin
                sc_ra = taddr(r_i, jm1);
                n_up = sc_rd;
            end
            ST_TDEC: begin
                if (match) begin
                    if (r_pos != '0) begin
                        tb_we = 1'b1;
                        n_pos = r_pos - Lw'(1);
                    end
                    n_i = im1;
                    n_j = jm1;
                end else if (r_up > sc_rd) begin
                    n_i = im1;
                end else begin
                    n_j = jm1;
                end
            end
            ST_ORD: begin
                if (!r_ov || acc_out) begin
                    n_pos = '0;
                    if (r_tot == '0) begin
                        n_ov = 1'b1;
                        n_out = '{out_symbol: '0, last_res: 1'b1, empty_res: 1'b1,
                                  truncated: r_ovf};
                        n_len1 = '0;
                        n_len2 = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            ST_OUT: begin
                if (!r_ov || acc_out) begin
                    n_ov = 1'b1;
                    n_out = '{out_symbol: tb_rd, last_res: (r_pos == r_tot - Lw'(1)),
                              empty_res: 1'b0, truncated: r_ovf};
                    n_pos = r_pos + Lw'(1);
                    if (r_pos == r_tot - Lw'(1)) begin
                        n_len1 = '0;
                        n_len2 = '0;
                        n_ovf = 1'b0;
                        n_tot = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD1;
            r_len1  <= '0;
            r_len2  <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_tot   <= '0;
        end else begin
            r_state <= n_state;
            r_len1  <= n_len1;
            r_len2  <= n_len2;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
            r_tot   <= (r_state == ST_TOT) ? '0 : n_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_pos  <= n_pos;
        r_up   <= n_up;
        r_diag <= n_diag;
        r_out  <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

// ----- rtl/lcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module lcs_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/lcs_checker.sv -----
// Port checker for the LCS core, bound to the top level.
`include "longest_common_subsequence_core_macros.svh"
module lcs_checker
    import lcs_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input t_lcs_in  i_data,
    input logic     o_valid,
    input logic     i_stall,
    input t_lcs_out o_data
);
    `LCS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled result changed")
    `LCS_ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, o_valid && o_data.empty_res, o_data.last_res && o_data.out_symbol == 8'd0, "empty result not final")
    `LCS_ASSERT_IMPL(a_busy, i_clk, i_rst_n, o_valid && !o_data.last_res, o_stall, "input taken mid-run")
    `LCS_ASSERT_NEXT(a_trunc, i_clk, i_rst_n, o_valid && !i_stall && !o_data.last_res, !o_valid || o_data.truncated == $past(o_data.truncated), "truncated flag varies")
endmodule

bind longest_common_subsequence_core lcs_checker u_lcs_checker (.*);

// ----- tb/sv/longest_common_subsequence_core_tb.sv -----
// Testbench for the LCS core: random and directed sequence pairs checked against a local model.
module longest_common_subsequence_core_tb;
    import lcs_pkg::*;

    localparam int MaxLen = LcsMaxLen;
    localparam int StallLimit = 200000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_lcs_in  i_data = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_lcs_out o_data;

    longest_common_subsequence_core u_top (.*);

    always #1 i_clk = ~i_clk;

    t_lcs_in  pending_items[$];
    t_lcs_out expected_symbols[$];

    logic [7:0] seq_a[MaxLen];
    logic [7:0] seq_b[MaxLen];
    int         len_a;
    int         len_b;
    logic       overflow;
    logic       loading_second;

    int  errors;
    int  results_seen;
    int  runs_done;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    bit  in_taken = 1'b0;

    function automatic void add_item(t_lcs_in item);
        pending_items.insert(pending_items.size(), item);
    endfunction

    function automatic void predict_lcs();
        int score[MaxLen + 1][MaxLen + 1];
        logic [7:0] common[$];
        int r;
        int c;
        t_lcs_out res;
        for (r = 0; r <= len_a; r++) begin
            for (c = 0; c <= len_b; c++) begin
                if (r == 0 || c == 0) begin
                    score[r][c] = 0;
                end else if (seq_a[r-1] == seq_b[c-1]) begin
                    score[r][c] = score[r-1][c-1] + 1;
                end else begin
                    score[r][c] = (score[r-1][c] > score[r][c-1]) ?
                                  score[r-1][c] : score[r][c-1];
                end
            end
        end
        r = len_a;
        c = len_b;
        while (r >= 1 && c >= 1) begin
            if (seq_a[r-1] == seq_b[c-1]) begin
                common.push_front(seq_a[r-1]);
                r--;
                c--;
            end else if (score[r-1][c] > score[r][c-1]) begin
                r--;
            end else begin
                c--;
            end
        end
        if (common.size() == 0) begin
            res = '{out_symbol: 8'd0, last_res: 1'b1, empty_res: 1'b1, truncated: overflow};
            expected_symbols.insert(expected_symbols.size(), res);
        end else begin
            foreach (common[k]) begin
                res = '{out_symbol: common[k], last_res: (k == common.size() - 1),
                        empty_res: 1'b0, truncated: overflow};
                expected_symbols.insert(expected_symbols.size(), res);
            end
        end
        len_a = 0;
        len_b = 0;
        overflow = 1'b0;
        loading_second = 1'b0;
        runs_done++;
    endfunction

    function automatic void apply_transfer(t_lcs_in item);
        if (item.op != (loading_second ? OpSecond : OpFirst)) begin
            return;
        end
        if (item.has_symbol) begin
            if (!loading_second) begin
                if (len_a < MaxLen) begin
                    seq_a[len_a] = item.symbol;
                    len_a++;
                end else begin
                    overflow = 1'b1;
                end
            end else begin
                if (len_b < MaxLen) begin
                    seq_b[len_b] = item.symbol;
                    len_b++;
                end else begin
                    overflow = 1'b1;
                end
            end
        end
        if (item.last) begin
            if (!loading_second) begin
                loading_second = 1'b1;
            end else begin
                predict_lcs();
            end
        end
    endfunction

    function automatic t_lcs_in make_item(logic op, logic [7:0] sym, logic has, logic last);
        t_lcs_in item;
        item.op = op;
        item.symbol = sym;
        item.has_symbol = has;
        item.last = last;
        return item;
    endfunction

    task automatic queue_sequence(logic op, int len, int alphabet, bit bare_end);
        int k;
        for (k = 0; k < len; k++) begin
            add_item(make_item(op, 8'($urandom_range(alphabet - 1) ^
                ($urandom_range(1) ? 8'hF0 : 8'h00)), 1'b1,
                (!bare_end && k == len - 1)));
        end
        if (bare_end || len == 0) begin
            add_item(make_item(op, 8'($urandom), 1'b0, 1'b1));
        end
    endtask

    task automatic queue_pair(int len1, int len2, int alphabet);
        queue_sequence(OpFirst, len1, alphabet, $urandom_range(3) == 0);
        if ($urandom_range(4) == 0) begin
            add_item(make_item(OpFirst, 8'($urandom), 1'($urandom), 1'($urandom)));
        end
        queue_sequence(OpSecond, len2, alphabet, $urandom_range(3) == 0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
                i_data <= t_lcs_in'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_lcs_out want;
        if (i_rst_n) begin
            in_taken <= i_valid && !o_stall;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_valid && !o_stall) begin
                apply_transfer(i_data);
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_symbols.size() == 0) begin
                    $display("%0t unexpected result: actual %p", $time, o_data);
                    errors++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (o_data !== want) begin
                        $display("%0t mismatch: expected %p actual %p", $time, want, o_data);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= StallLimit) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || i_valid || expected_symbols.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int size1;
        int size2;
        errors = 0;
        results_seen = 0;
        runs_done = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        len_a = 0;
        len_b = 0;
        overflow = 1'b0;
        loading_second = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 67;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_item(make_item(OpSecond, 8'hFF, 1'b1, 1'b1));
        add_item(make_item(OpFirst, 8'h00, 1'b1, 1'b0));
        add_item(make_item(OpFirst, 8'hFF, 1'b1, 1'b1));
        add_item(make_item(OpFirst, 8'h55, 1'b1, 1'b1));
        add_item(make_item(OpSecond, 8'hFF, 1'b1, 1'b0));
        add_item(make_item(OpSecond, 8'h00, 1'b1, 1'b1));
        add_item(make_item(OpFirst, 8'h00, 1'b0, 1'b1));
        add_item(make_item(OpSecond, 8'h00, 1'b0, 1'b1));
        add_item(make_item(OpFirst, 8'hAA, 1'b1, 1'b1));
        add_item(make_item(OpSecond, 8'h55, 1'b1, 1'b1));
        add_item(make_item(OpFirst, 8'h12, 1'b1, 1'b0));
        add_item(make_item(OpFirst, 8'h34, 1'b1, 1'b1));
        add_item(make_item(OpSecond, 8'h34, 1'b1, 1'b0));
        add_item(make_item(OpSecond, 8'h12, 1'b1, 1'b1));
        drain();

        for (n = 0; n < MaxLen + 3; n++) begin
            add_item(make_item(OpFirst, 8'(n % 3), 1'b1, n == MaxLen + 2));
        end
        for (n = 0; n < MaxLen + 2; n++) begin
            add_item(make_item(OpSecond, 8'(n % 5), 1'b1, 1'b0));
        end
        add_item(make_item(OpSecond, 8'h00, 1'b0, 1'b1));
        drain();

        for (int phase_sel = 0; phase_sel < 3; phase_sel++) begin
            send_idle_pct = (phase_sel == 0) ? 10 : (phase_sel == 1) ? 67 : 0;
            recv_idle_pct = (phase_sel == 0) ? 67 : (phase_sel == 1) ? 10 : 0;
            if (phase_sel == 2) begin
                hold_cycles = 3000;
            end
            for (n = 0; n < 5; n++) begin
                size1 = ($urandom_range(9) == 0) ? $urandom_range(MaxLen + 2) :
                        $urandom_range(10);
                size2 = ($urandom_range(9) == 0) ? $urandom_range(MaxLen + 2) :
                        $urandom_range(10);
                queue_pair(size1, size2, $urandom_range(1) ? 4 : 256);
                if ($urandom_range(5) == 0) begin
                    add_item(make_item(OpSecond, 8'($urandom), 1'($urandom), 1'b1));
                end
            end
            drain();
        end

        $display("Covered %0d LCS runs with %0d results checked,", runs_done, results_seen);
        $display("including empty answers, truncated inputs and wrong-op items.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_ram.sv
rtl/longest_common_subsequence_core.sv
rtl/lcs_checker.sv
tb/sv/longest_common_subsequence_core_tb.sv
